@@ hw/rtl/ugnb_pkg.sv @@
// Shared constants and the neighbourhood visiting order for the grid binning block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ugnb_pkg;

  localparam int GRID_CELLS_DEF = 4096;
  localparam int CELL_SLOTS_DEF = 16;
  localparam int LIST_CAP_DEF   = 64;

  localparam int NBR_CELLS = 27;

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 16;
  localparam int LOC_W   = 10;
  localparam int RAD_W   = 8;
  localparam int EXT_W   = 7;
  localparam int LIM_W   = 5;
  localparam int TOTAL_W = 9;

  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_COUNT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LIST  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CHECK = 2'd3;

  localparam logic [2:0] REG_RADIUS_X = 3'd0;
  localparam logic [2:0] REG_RADIUS_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS_Z = 3'd2;
  localparam logic [2:0] REG_CELLS_X  = 3'd3;
  localparam logic [2:0] REG_CELLS_Y  = 3'd4;
  localparam logic [2:0] REG_CELLS_Z  = 3'd5;
  localparam logic [2:0] REG_LIMIT    = 3'd6;

  // Offsets {dx,dy,dz}, 2-bit two's complement each: centre, faces, edges, corners.
  function automatic logic [5:0] ring_off(input logic [4:0] o);
    logic [5:0] r;
    unique case (o)
      5'd0:  r = {2'b00, 2'b00, 2'b00};
      5'd1:  r = {2'b01, 2'b00, 2'b00};
      5'd2:  r = {2'b11, 2'b00, 2'b00};
      5'd3:  r = {2'b00, 2'b01, 2'b00};
      5'd4:  r = {2'b00, 2'b11, 2'b00};
      5'd5:  r = {2'b00, 2'b00, 2'b01};
      5'd6:  r = {2'b00, 2'b00, 2'b11};
      5'd7:  r = {2'b01, 2'b01, 2'b00};
      5'd8:  r = {2'b01, 2'b11, 2'b00};
      5'd9:  r = {2'b11, 2'b01, 2'b00};
      5'd10: r = {2'b11, 2'b11, 2'b00};
      5'd11: r = {2'b01, 2'b00, 2'b01};
      5'd12: r = {2'b01, 2'b00, 2'b11};
      5'd13: r = {2'b11, 2'b00, 2'b01};
      5'd14: r = {2'b11, 2'b00, 2'b11};
      5'd15: r = {2'b00, 2'b01, 2'b01};
      5'd16: r = {2'b00, 2'b01, 2'b11};
      5'd17: r = {2'b00, 2'b11, 2'b01};
      5'd18: r = {2'b00, 2'b11, 2'b11};
      5'd19: r = {2'b01, 2'b01, 2'b01};
      5'd20: r = {2'b01, 2'b01, 2'b11};
      5'd21: r = {2'b01, 2'b11, 2'b01};
      5'd22: r = {2'b01, 2'b11, 2'b11};
      5'd23: r = {2'b11, 2'b01, 2'b01};
      5'd24: r = {2'b11, 2'b01, 2'b11};
      5'd25: r = {2'b11, 2'b11, 2'b01};
      5'd26: r = {2'b11, 2'b11, 2'b11};
      default: r = 6'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/uniform_grid_neighbour_binning.sv @@
// Uniform grid neighbour binning: top level with cell metadata and slot memories.
// Depends on ugnb_pkg.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block sweeps the cell metadata memory clear, one cell a cycle, so
// in_ready stays low until all GRID_CELLS cells are clear; configuration writes are
// taken throughout. One word is handled at a time. Every word first divides its location
// by the three radii, one quotient bit a cycle. An add then does one read-modify-write
// of its cell. Count, list and limit check walk the 27 neighbour cells (index products,
// then a metadata read for a cell inside the grid). A list then walks the cells again
// and reads their ids from the slot memory one at a time, each read then streamed out,
// up to LIST_CAP ids. Each memory has a single read port, so these steps run in turn.
// Results go through an output register; a stalled consumer holds the sequencer until
// that register frees. A cell whose count reaches cell_limit (clamped to CELL_SLOTS)
// and gets one more id is marked overflowed and empties; count and list then answer
// with status 1.
module uniform_grid_neighbour_binning
  import ugnb_pkg::*;
#(
  parameter int GRID_CELLS = GRID_CELLS_DEF,
  parameter int CELL_SLOTS = CELL_SLOTS_DEF,
  parameter int LIST_CAP   = LIST_CAP_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [4:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic      [31:0]         cfg_prdata,
  output logic                     cfg_pready,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [ID_W-1:0]     in_node_id,
  input  wire logic [LOC_W-1:0]    in_loc_x,
  input  wire logic [LOC_W-1:0]    in_loc_y,
  input  wire logic [LOC_W-1:0]    in_loc_z,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_status,
  output logic [TOTAL_W-1:0]       out_total,
  output logic                     out_limit_hit,
  output logic [ID_W-1:0]          out_neighbour_id,
  output logic                     out_neighbour_valid,
  output logic                     out_last
);

  localparam int CI_W  = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int SA_W  = $clog2(GRID_CELLS * CELL_SLOTS);
  localparam int CNT_W = $clog2(CELL_SLOTS + 1);
  localparam int MW    = CNT_W + 1;
  localparam int TOT_W = $clog2(NBR_CELLS * CELL_SLOTS + 1);
  localparam int N_W   = $clog2(LIST_CAP + 1);
  localparam int CRD_W = LOC_W + 2;
  localparam int PL_W  = 2 * EXT_W;
  localparam int PZ_W  = EXT_W + PL_W;
  localparam int SUM_W = PZ_W + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_CALC = 4'd2;
  localparam logic [3:0] ST_ADDR = 4'd3;
  localparam logic [3:0] ST_META = 4'd4;
  localparam logic [3:0] ST_END  = 4'd5;
  localparam logic [3:0] ST_SRD  = 4'd6;
  localparam logic [3:0] ST_SWT  = 4'd7;

  localparam logic [4:0] LAST_OFF = 5'(NBR_CELLS - 1);

  // ---------------- configuration ----------------
  logic [RAD_W-1:0] rad_r [3];
  logic [EXT_W-1:0] ext_r [3];
  logic [LIM_W-1:0] limit_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r[0] <= RAD_W'(1);
      rad_r[1] <= RAD_W'(1);
      rad_r[2] <= RAD_W'(1);
      ext_r[0] <= EXT_W'(16);
      ext_r[1] <= EXT_W'(16);
      ext_r[2] <= EXT_W'(16);
      limit_r  <= LIM_W'(16);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_RADIUS_X: rad_r[0] <= cfg_pwdata[RAD_W-1:0];
        REG_RADIUS_Y: rad_r[1] <= cfg_pwdata[RAD_W-1:0];
        REG_RADIUS_Z: rad_r[2] <= cfg_pwdata[RAD_W-1:0];
        REG_CELLS_X:  ext_r[0] <= cfg_pwdata[EXT_W-1:0];
        REG_CELLS_Y:  ext_r[1] <= cfg_pwdata[EXT_W-1:0];
        REG_CELLS_Z:  ext_r[2] <= cfg_pwdata[EXT_W-1:0];
        REG_LIMIT:    limit_r  <= cfg_pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_RADIUS_X: cfg_prdata = 32'(rad_r[0]);
      REG_RADIUS_Y: cfg_prdata = 32'(rad_r[1]);
      REG_RADIUS_Z: cfg_prdata = 32'(rad_r[2]);
      REG_CELLS_X:  cfg_prdata = 32'(ext_r[0]);
      REG_CELLS_Y:  cfg_prdata = 32'(ext_r[1]);
      REG_CELLS_Z:  cfg_prdata = 32'(ext_r[2]);
      REG_LIMIT:    cfg_prdata = 32'(limit_r);
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // effective per-cell limit, clamped to the store
  logic [CNT_W-1:0] lim;
  assign lim = ({2'b00, limit_r} > 7'(CELL_SLOTS)) ? CNT_W'(CELL_SLOTS)
                                                   : CNT_W'(limit_r);

  // ---------------- memories ----------------
  // metadata word: {overflowed, count}
  logic [MW-1:0]   meta_mem [GRID_CELLS];
  logic [MW-1:0]   meta_q;
  logic            meta_re, meta_we;
  logic [CI_W-1:0] meta_ra, meta_wa;
  logic [MW-1:0]   meta_wd;

  logic [ID_W-1:0] slot_mem [GRID_CELLS * CELL_SLOTS];
  logic [ID_W-1:0] slot_q;
  logic            slot_re, slot_we;
  logic [SA_W-1:0] slot_ra, slot_wa;

  // ---------------- clearing pass ----------------
  logic            clr_busy_r;
  logic [CI_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + CI_W'(1);
      if (32'(clr_cnt_r) == GRID_CELLS - 1) clr_busy_r <= 1'b0;
    end
  end

  // ---------------- sequencer ----------------
  logic [3:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [LOC_W-1:0]  quo_r [3];
  logic [LOC_W-1:0]  quo_nxt [3];
  logic [RAD_W-1:0]  rem_r [3];
  logic [RAD_W-1:0]  rem_nxt [3];
  logic [3:0]        div_cnt_r, div_cnt_nxt;
  logic [4:0]        off_r, off_nxt;
  logic              pass2_r, pass2_nxt;
  logic              any_over_r, any_over_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]  s_r, s_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              in_grid_r, in_grid_nxt;
  logic [PZ_W-1:0]   prod_z_r, prod_z_nxt;
  logic [PL_W-1:0]   prod_y_r, prod_y_nxt;
  logic [EXT_W-1:0]  ncx_r, ncx_nxt;
  logic [CI_W-1:0]   idx_r, idx_nxt;
  logic [PL_W-1:0]   plane_r, plane_nxt;

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (meta_re) meta_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= id_r;
    if (slot_re) slot_q <= slot_mem[slot_ra];
  end

  // output register
  logic               ov_r, ov_nxt;
  logic               o_status_r, o_status_nxt;
  logic [TOTAL_W-1:0] o_total_r, o_total_nxt;
  logic               o_hit_r, o_hit_nxt;
  logic [ID_W-1:0]    o_id_r, o_id_nxt;
  logic               o_nv_r, o_nv_nxt;
  logic               o_last_r, o_last_nxt;

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && !clr_busy_r;

  // combinational helpers
  logic [RAD_W-1:0]        rad_eff [3];
  logic [RAD_W:0]          dsh [3];
  logic [5:0]              offs;
  logic signed [CRD_W-1:0] ncrd [3];
  logic                    ok_ax [3];
  logic [SUM_W-1:0]        idx_sum;
  logic                    cell_ok;
  logic [CNT_W-1:0]        m_cnt;
  logic                    m_ovf;
  logic [N_W-1:0]          list_lim;
  logic [N_W-1:0]          n_inc;

  always_comb begin
    offs = ring_off(off_r);
    for (int a = 0; a < 3; a++) begin
      rad_eff[a] = (rad_r[a] == '0) ? RAD_W'(1) : rad_r[a];
      dsh[a]     = {rem_r[a], quo_r[a][LOC_W-1]};
      ncrd[a]    = signed'({2'b00, quo_r[a]}) +
                   CRD_W'(signed'(offs[5-2*a -: 2]));
      ok_ax[a]   = (ncrd[a] >= 0) &&
                   (ncrd[a] < signed'(CRD_W'(ext_r[a])));
    end
  end

  assign idx_sum  = SUM_W'(prod_z_r) + SUM_W'(prod_y_r) + SUM_W'(ncx_r);
  assign cell_ok  = in_grid_r && (32'(idx_sum) < GRID_CELLS);
  assign m_cnt    = meta_q[CNT_W-1:0];
  assign m_ovf    = meta_q[CNT_W];
  assign list_lim = (32'(total_r) < LIST_CAP) ? N_W'(total_r) : N_W'(LIST_CAP);
  assign n_inc    = n_r + N_W'(1);

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    id_nxt       = id_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    div_cnt_nxt  = div_cnt_r;
    off_nxt      = off_r;
    pass2_nxt    = pass2_r;
    any_over_nxt = any_over_r;
    total_nxt    = total_r;
    n_nxt        = n_r;
    s_nxt        = s_r;
    cnt_nxt      = cnt_r;
    in_grid_nxt  = in_grid_r;
    prod_z_nxt   = prod_z_r;
    prod_y_nxt   = prod_y_r;
    ncx_nxt      = ncx_r;
    idx_nxt      = idx_r;
    plane_nxt    = plane_r;
    ov_nxt       = ov_r && !out_ready;
    o_status_nxt = o_status_r;
    o_total_nxt  = o_total_r;
    o_hit_nxt    = o_hit_r;
    o_id_nxt     = o_id_r;
    o_nv_nxt     = o_nv_r;
    o_last_nxt   = o_last_r;
    meta_re      = 1'b0;
    meta_ra      = idx_sum[CI_W-1:0];
    meta_we      = 1'b0;
    meta_wa      = idx_r;
    meta_wd      = '0;
    slot_re      = 1'b0;
    slot_ra      = SA_W'(idx_r * CELL_SLOTS) + SA_W'(s_r);
    slot_we      = 1'b0;
    slot_wa      = SA_W'(idx_r * CELL_SLOTS) + SA_W'(m_cnt);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          func_nxt     = in_func;
          id_nxt       = in_node_id;
          quo_nxt[0]   = in_loc_x;
          quo_nxt[1]   = in_loc_y;
          quo_nxt[2]   = in_loc_z;
          rem_nxt[0]   = '0;
          rem_nxt[1]   = '0;
          rem_nxt[2]   = '0;
          div_cnt_nxt  = '0;
          off_nxt      = '0;
          pass2_nxt    = 1'b0;
          any_over_nxt = 1'b0;
          total_nxt    = '0;
          n_nxt        = '0;
          plane_nxt    = ext_r[0] * ext_r[1];
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per axis each cycle
        for (int a = 0; a < 3; a++) begin
          if (dsh[a] >= {1'b0, rad_eff[a]}) begin
            rem_nxt[a] = RAD_W'(dsh[a] - {1'b0, rad_eff[a]});
            quo_nxt[a] = {quo_r[a][LOC_W-2:0], 1'b1};
          end else begin
            rem_nxt[a] = dsh[a][RAD_W-1:0];
            quo_nxt[a] = {quo_r[a][LOC_W-2:0], 1'b0};
          end
        end
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'(LOC_W - 1)) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        in_grid_nxt = ok_ax[0] && ok_ax[1] && ok_ax[2];
        prod_z_nxt  = ncrd[2][EXT_W-1:0] * plane_r;
        prod_y_nxt  = ncrd[1][EXT_W-1:0] * ext_r[0];
        ncx_nxt     = ncrd[0][EXT_W-1:0];
        state_nxt   = ST_ADDR;
      end
      ST_ADDR: begin
        idx_nxt = idx_sum[CI_W-1:0];
        if (cell_ok) begin
          meta_re   = 1'b1;
          state_nxt = ST_META;
        end else if (func_r == FN_ADD) begin
          state_nxt = ST_IDLE;
        end else if (off_r == LAST_OFF) begin
          state_nxt = pass2_r ? ST_IDLE : ST_END;
        end else begin
          off_nxt   = off_r + 5'd1;
          state_nxt = ST_CALC;
        end
      end
      ST_META: begin
        if (func_r == FN_ADD) begin
          state_nxt = ST_IDLE;
          if (!m_ovf) begin
            meta_we = 1'b1;
            if (m_cnt >= lim) begin
              meta_wd = {1'b1, CNT_W'(0)};
            end else begin
              slot_we = 1'b1;
              meta_wd = {1'b0, m_cnt + CNT_W'(1)};
            end
          end
        end else if (pass2_r && m_cnt != '0) begin
          cnt_nxt   = m_cnt;
          s_nxt     = '0;
          state_nxt = ST_SRD;
        end else begin
          if (!pass2_r) begin
            if (m_ovf) any_over_nxt = 1'b1;
            else       total_nxt = total_r + TOT_W'(m_cnt);
          end
          if (off_r == LAST_OFF) begin
            state_nxt = pass2_r ? ST_IDLE : ST_END;
          end else begin
            off_nxt   = off_r + 5'd1;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_END: begin
        if (func_r == FN_LIST && !any_over_r && total_r != '0) begin
          pass2_nxt = 1'b1;
          off_nxt   = '0;
          state_nxt = ST_CALC;
        end else if (out_free) begin
          ov_nxt       = 1'b1;
          o_status_nxt = (func_r != FN_CHECK) && any_over_r;
          o_total_nxt  = (func_r == FN_COUNT && !any_over_r) ? TOTAL_W'(total_r)
                                                               : '0;
          o_hit_nxt    = (func_r == FN_CHECK) && any_over_r;
          o_id_nxt     = '0;
          o_nv_nxt     = 1'b0;
          o_last_nxt   = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SRD: begin
        slot_re   = 1'b1;
        state_nxt = ST_SWT;
      end
      ST_SWT: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_status_nxt = 1'b0;
          o_total_nxt  = '0;
          o_hit_nxt    = 1'b0;
          o_id_nxt     = slot_q;
          o_nv_nxt     = 1'b1;
          o_last_nxt   = (n_inc == list_lim);
          n_nxt        = n_inc;
          s_nxt        = s_r + CNT_W'(1);
          if (n_inc == list_lim) begin
            state_nxt = ST_IDLE;
          end else if (s_r + CNT_W'(1) < cnt_r) begin
            state_nxt = ST_SRD;
          end else if (off_r == LAST_OFF) begin
            state_nxt = ST_IDLE;
          end else begin
            off_nxt   = off_r + 5'd1;
            state_nxt = ST_CALC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // clearing pass owns the metadata write port
    if (clr_busy_r) begin
      meta_we = 1'b1;
      meta_wa = clr_cnt_r;
      meta_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    id_r       <= id_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    off_r      <= off_nxt;
    pass2_r    <= pass2_nxt;
    any_over_r <= any_over_nxt;
    total_r    <= total_nxt;
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    cnt_r      <= cnt_nxt;
    in_grid_r  <= in_grid_nxt;
    prod_z_r   <= prod_z_nxt;
    prod_y_r   <= prod_y_nxt;
    ncx_r      <= ncx_nxt;
    idx_r      <= idx_nxt;
    plane_r    <= plane_nxt;
    o_status_r <= o_status_nxt;
    o_total_r  <= o_total_nxt;
    o_hit_r    <= o_hit_nxt;
    o_id_r     <= o_id_nxt;
    o_nv_r     <= o_nv_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid           = ov_r;
  assign out_status          = o_status_r;
  assign out_total           = o_total_r;
  assign out_limit_hit       = o_hit_r;
  assign out_neighbour_id    = o_id_r;
  assign out_neighbour_valid = o_nv_r;
  assign out_last            = o_last_r;

  // ---------------- checks ----------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready) else $error("word accepted during clearing pass");

  a_slot_only_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWT) |-> (pass2_r && func_r == FN_LIST))
    else $error("slot stream outside list pass");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWT) |-> (32'(n_r) < LIST_CAP)) else $error("list count beyond cap");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !clr_busy_r) |-> !meta_we && !slot_we)
    else $error("memory write while idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> $stable(o_id_r) && $stable(o_last_r))
    else $error("held result overwritten");

endmodule
`default_nettype wire

@@ tb/tb_uniform_grid_neighbour_binning.sv @@
// Self-checking testbench for uniform_grid_neighbour_binning: directed and random words,
// with a bit-exact predictor of the cell store and its neighbourhood queries.
// Depends on ugnb_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_uniform_grid_neighbour_binning;
  import ugnb_pkg::*;

  localparam int NCELLS   = 4096;
  localparam int NSLOTS   = 16;
  localparam int CAP      = 64;
  localparam int WDOG_MAX = 20000;  // idle limit, above the clear sweep and any query
  localparam int SETTLE   = 300;    // an add gives no result, so let it finish

  // visiting order: centre, faces, edges, corners
  localparam int OFF_X[27] = '{0, 1,-1, 0, 0, 0, 0, 1, 1,-1,-1, 1, 1,-1,-1,
                               0, 0, 0, 0, 1, 1, 1, 1,-1,-1,-1,-1};
  localparam int OFF_Y[27] = '{0, 0, 0, 1,-1, 0, 0, 1,-1, 1,-1, 0, 0, 0, 0,
                               1, 1,-1,-1, 1, 1,-1,-1, 1, 1,-1,-1};
  localparam int OFF_Z[27] = '{0, 0, 0, 0, 0, 1,-1, 0, 0, 0, 0, 1,-1, 1,-1,
                               1,-1, 1,-1, 1,-1, 1,-1, 1,-1, 1,-1};

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [LOC_W-1:0]  x, y, z;
  } grid_word_t;

  typedef struct {
    bit               status;
    bit [TOTAL_W-1:0] total;
    bit               hit;
    bit [ID_W-1:0]    nid;
    bit               nvalid;
    bit               last;
  } nbr_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [ID_W-1:0] in_node_id = '0;
  logic [LOC_W-1:0] in_loc_x = '0, in_loc_y = '0, in_loc_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status, out_limit_hit, out_neighbour_valid, out_last;
  logic [TOTAL_W-1:0] out_total;
  logic [ID_W-1:0] out_neighbour_id;

  uniform_grid_neighbour_binning dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow registers and cell store
  int unsigned radius[3];
  int unsigned extent[3];
  int unsigned cell_lim;
  bit [4:0]      cnt_mem[NCELLS];
  bit            ovf_mem[NCELLS];
  bit [ID_W-1:0] slot_mem[NCELLS*NSLOTS];

  grid_word_t pending[$];
  nbr_word_t  awaited[$];
  int words_queued = 0, words_taken = 0, errs = 0;
  int send_gap = 0, rcv_gap = 0, idle_cycles = 0;
  bit burst = 0, in_took = 0, cfg_hit = 0;
  grid_word_t cur;

  // random-word shaping
  int unsigned hot[3];
  int add_pct = 60;

  function automatic int cell_at(int cx, int cy, int cz);
    int unsigned idx;
    if (cx < 0 || cy < 0 || cz < 0) return -1;
    if (cx >= extent[0] || cy >= extent[1] || cz >= extent[2]) return -1;
    idx = cz * extent[0] * extent[1] + cy * extent[0] + cx;
    return (idx >= NCELLS) ? -1 : int'(idx);
  endfunction

  function automatic int unsigned eff(int unsigned r);
    return (r == 0) ? 1 : r;
  endfunction

  // store update and expected words for one accepted word
  task automatic bin_and_predict(input grid_word_t w);
    int cx, cy, cz, c, n, tot;
    int near[27];
    int unsigned lim;
    bit any_ovf;
    nbr_word_t r;
    cx = w.x / eff(radius[0]);
    cy = w.y / eff(radius[1]);
    cz = w.z / eff(radius[2]);
    r = '{default: 0};
    if (w.func == FN_ADD) begin
      c = cell_at(cx, cy, cz);
      lim = (cell_lim > NSLOTS) ? NSLOTS : cell_lim;
      if (c < 0 || ovf_mem[c]) return;
      if (cnt_mem[c] >= lim) begin
        ovf_mem[c] = 1;
        cnt_mem[c] = 0;
      end else begin
        slot_mem[c*NSLOTS + cnt_mem[c]] = w.id;
        cnt_mem[c]++;
      end
      return;
    end
    any_ovf = 0;
    tot = 0;
    for (int o = 0; o < 27; o++) begin
      near[o] = cell_at(cx + OFF_X[o], cy + OFF_Y[o], cz + OFF_Z[o]);
      if (near[o] >= 0) begin
        if (ovf_mem[near[o]]) any_ovf = 1;
        else tot += cnt_mem[near[o]];
      end
    end
    r.last = 1;
    if (w.func == FN_CHECK) begin
      r.hit = any_ovf;
      awaited.insert(awaited.size(), r);
    end else if (any_ovf) begin
      r.status = 1;
      awaited.insert(awaited.size(), r);
    end else if (w.func == FN_COUNT) begin
      r.total = tot;
      awaited.insert(awaited.size(), r);
    end else begin
      n = 0;
      for (int o = 0; o < 27 && n < CAP; o++) begin
        if (near[o] < 0) continue;
        for (int s = 0; s < cnt_mem[near[o]] && n < CAP; s++) begin
          r = '{default: 0};
          r.nvalid = 1;
          r.nid = slot_mem[near[o]*NSLOTS + s];
          awaited.insert(awaited.size(), r);
          n++;
        end
      end
      if (n == 0) begin
        r = '{default: 0};
        r.last = 1;
        awaited.insert(awaited.size(), r);
      end else begin
        awaited[$].last = 1;
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  // driver: one payload held until taken, random gap per word, occasional bursts
  always @(negedge clk) begin
    if (in_valid && !in_took) begin
      // hold
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending.size() > 0) begin
      cur = pending.pop_front();
      in_func <= cur.func;
      in_node_id <= cur.id;
      in_loc_x <= cur.x;
      in_loc_y <= cur.y;
      in_loc_z <= cur.z;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rcv_gap > 0) begin
      rcv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    nbr_word_t e;
    in_took = 0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_took = 1;
        words_taken++;
        bin_and_predict('{in_func, in_node_id, in_loc_x, in_loc_y, in_loc_z});
        if ($urandom_range(15, 0) == 0) burst = !burst;
        send_gap = burst ? 0 : $urandom_range(8, 0);
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          e = awaited.pop_front();
          check_field("status", e.status, out_status);
          check_field("total", e.total, out_total);
          check_field("limit_hit", e.hit, out_limit_hit);
          check_field("neighbour_id", e.nid, out_neighbour_id);
          check_field("neighbour_valid", e.nvalid, out_neighbour_valid);
          check_field("last", e.last, out_last);
        end
        rcv_gap = burst ? 0 : $urandom_range(8, 0);
      end
    end
    if (!rst_n || in_took || (out_valid && out_ready) || cfg_hit) idle_cycles = 0;
    else idle_cycles++;
    cfg_hit = 0;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_hit = 1;
    case (idx)
      REG_RADIUS_X: radius[0] = val & 8'hFF;
      REG_RADIUS_Y: radius[1] = val & 8'hFF;
      REG_RADIUS_Z: radius[2] = val & 8'hFF;
      REG_CELLS_X:  extent[0] = val & 7'h7F;
      REG_CELLS_Y:  extent[1] = val & 7'h7F;
      REG_CELLS_Z:  extent[2] = val & 7'h7F;
      REG_LIMIT:    cell_lim  = val & 5'h1F;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_grid(input int unsigned r[3], input int unsigned ext[3],
                          input int unsigned lim);
    reg_write(REG_RADIUS_X, r[0]);
    reg_write(REG_RADIUS_Y, r[1]);
    reg_write(REG_RADIUS_Z, r[2]);
    reg_write(REG_CELLS_X, ext[0]);
    reg_write(REG_CELLS_Y, ext[1]);
    reg_write(REG_CELLS_Z, ext[2]);
    reg_write(REG_LIMIT, lim);
  endtask

  task automatic queue_word(input logic [FUNC_W-1:0] f, input int unsigned id,
                            input int unsigned x, input int unsigned y, input int unsigned z);
    grid_word_t w;
    w = '{f, id[ID_W-1:0], x[LOC_W-1:0], y[LOC_W-1:0], z[LOC_W-1:0]};
    pending.insert(pending.size(), w);
    words_queued++;
  endtask

  // sender holds off here until every result is in and the block has gone quiet
  task automatic drain;
    do begin
      @(posedge clk);
      #1;
    end while (words_taken != words_queued || awaited.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly adds and queries packed around a 3x3x3 block of cells, some pure noise
  task automatic random_words(input int n);
    int unsigned loc[3], rr, top;
    logic [FUNC_W-1:0] f;
    for (int a = 0; a < 3; a++) begin
      top = (extent[a] > 3) ? extent[a] - 3 : 0;
      hot[a] = $urandom_range(top, 0) * eff(radius[a]);
      if (hot[a] > 1023) hot[a] = $urandom_range(1023, 0);
    end
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(99, 0) < add_pct) ? FN_ADD
                                              : FUNC_W'(FN_COUNT + $urandom_range(2, 0));
      if ($urandom_range(99, 0) < 15) begin
        queue_word(FUNC_W'($urandom_range(3, 0)), $urandom, $urandom_range(1023, 0),
                   $urandom_range(1023, 0), $urandom_range(1023, 0));
      end else begin
        for (int a = 0; a < 3; a++) begin
          rr = hot[a] + $urandom_range(3 * eff(radius[a]) - 1, 0);
          loc[a] = (rr > 1023) ? 1023 : rr;
        end
        queue_word(f, $urandom, loc[0], loc[1], loc[2]);
      end
    end
    drain();
  endtask

  initial begin
    int unsigned r[3], ext[3];
    foreach (cnt_mem[i]) begin
      cnt_mem[i] = 0;
      ovf_mem[i] = 0;
    end
    radius = '{1, 1, 1};
    extent = '{16, 16, 16};
    cell_lim = 16;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: small limit so one cell overflows quickly
    set_grid('{1, 1, 1}, '{16, 16, 16}, 2);
    queue_word(FN_ADD, 0, 0, 0, 0);
    queue_word(FN_ADD, 16'hFFFF, 1, 0, 0);
    queue_word(FN_ADD, 1234, 0, 0, 0);
    queue_word(FN_COUNT, 0, 0, 0, 0);
    queue_word(FN_LIST, 0, 0, 0, 0);
    queue_word(FN_CHECK, 0, 0, 0, 0);
    queue_word(FN_LIST, 0, 1023, 1023, 1023);    // every cell off the grid: empty list
    queue_word(FN_COUNT, 0, 1023, 1023, 1023);
    queue_word(FN_ADD, 99, 1023, 1023, 1023);    // off the grid, dropped
    queue_word(FN_LIST, 0, 9, 9, 9);             // empty neighbourhood inside the grid
    queue_word(FN_ADD, 7, 5, 5, 5);
    queue_word(FN_ADD, 8, 5, 5, 5);
    queue_word(FN_ADD, 9, 5, 5, 5);              // one past the limit: cell overflows
    queue_word(FN_COUNT, 0, 5, 5, 5);
    queue_word(FN_LIST, 0, 6, 5, 5);
    queue_word(FN_CHECK, 0, 4, 4, 4);
    queue_word(FN_ADD, 10, 5, 5, 5);             // overflowed cell ignores adds
    queue_word(FN_CHECK, 0, 15, 15, 15);
    queue_word(FN_LIST, 0, 15, 15, 15);
    drain();

    // dense phase: enough ids near one spot to hit the list cap
    add_pct = 75;
    set_grid('{1, 1, 1}, '{16, 16, 16}, 16);
    random_words(90);

    // zero radii on a 64x64x64 grid: most cells lie beyond the store
    add_pct = 60;
    set_grid('{0, 0, 0}, '{64, 64, 64}, 16);
    random_words(70);

    // widest radius, single-cell grid, zero limit
    set_grid('{255, 255, 255}, '{1, 1, 1}, 0);
    random_words(50);

    repeat (3) begin
      foreach (r[a]) begin
        r[a] = $urandom_range(8, 1);
        ext[a] = $urandom_range(64, 1);
      end
      set_grid(r, ext, $urandom_range(16, 0));
      random_words(80);
    end

    if (errs == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
